// ===== rtl/bara_pkg.sv =====
// Shared constants, operation codes and the command type of the bit array block.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package bara_pkg;

    // Store geometry.
    localparam int TOTAL_BITS = 1024;
    localparam int WORD_BITS  = 32;
    localparam int WORD_COUNT = (TOTAL_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int OFF_W      = $clog2(WORD_BITS);
    localparam int WIDX_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

    // Port field widths.
    localparam int INDEX_W = 10;
    localparam int END_W   = 11;

    // Command queue between the front and the back.
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // Operation codes carried in the func field.
    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_GET   = 2'd1;
    localparam logic [1:0] FUNC_SET   = 2'd2;
    localparam logic [1:0] FUNC_ANY   = 2'd3;

    typedef logic [WORD_BITS-1:0] word_t;

    // A classified operation, ready for the back end to carry out.
    typedef struct packed {
        logic [1:0]        func;
        logic              idx_ok;
        logic [WIDX_W-1:0] word;
        logic [OFF_W-1:0]  offset;
        logic              value;
        logic              range_empty;
        logic [WIDX_W-1:0] first_word;
        logic [WIDX_W-1:0] last_word;
        logic [OFF_W-1:0]  first_off;
        logic [OFF_W:0]    last_end;
    } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/bit_array_range_any_core.sv =====
// Bit array with get, set, clear and any-in-range query: a two-deep command
// queue in the front parts the input side from the word store in the back, and a
// result register parts the back from the output side. In the back end a clear
// ends as it is taken, a set reads its word and writes it back, a get reads its
// word for the result register, and an any query reads the words of the range
// in turn to the first hit: the single store read port delivers one 32-bit word a cycle.
// Bit 0 is the most significant bit of word 0. Reset needs no clearing pass.
// Depends on bara_pkg, bara_front and bara_back.
`default_nettype none

module bit_array_range_any_core
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic [1:0]                   func,
    input  wire logic [bara_pkg::INDEX_W-1:0] bit_index,
    input  wire logic                         bit_value,
    input  wire logic [bara_pkg::INDEX_W-1:0] range_start,
    input  wire logic [bara_pkg::END_W-1:0]   range_end,
    output logic                              empty,
    input  wire logic                         pop,
    output logic                              result_bit
);

    logic           cmd_valid;
    logic           cmd_take;
    bara_pkg::cmd_t cmd;

    // Classification and command queue.
    bara_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .func        (func),
        .bit_index   (bit_index),
        .bit_value   (bit_value),
        .range_start (range_start),
        .range_end   (range_end),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_take    (cmd_take)
    );

    // Word store, sequencer and result register.
    bara_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_take   (cmd_take),
        .empty      (empty),
        .pop        (pop),
        .result_bit (result_bit)
    );

endmodule

`default_nettype wire

// ===== rtl/bara_front.sv =====
// Front end: accepts operations, splits positions into word and bit offset, and
// queues the classified commands for the back end. Depends on bara_pkg.
`default_nettype none

module bara_front
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic [1:0]                   func,
    input  wire logic [bara_pkg::INDEX_W-1:0] bit_index,
    input  wire logic                         bit_value,
    input  wire logic [bara_pkg::INDEX_W-1:0] range_start,
    input  wire logic [bara_pkg::END_W-1:0]   range_end,
    output logic                              cmd_valid,
    output bara_pkg::cmd_t                    cmd,
    input  wire logic                         cmd_take
);

    logic [bara_pkg::END_W-1:0] idx_ext;
    logic [bara_pkg::END_W-1:0] start_ext;
    logic [bara_pkg::END_W-1:0] hi_sat;
    logic [bara_pkg::END_W-1:0] hi_m1;
    bara_pkg::cmd_t             cls;

    bara_pkg::cmd_t                     q_mem_reg [bara_pkg::CMDQ_DEPTH];
    logic [bara_pkg::CMDQ_PTR_W-1:0]    wr_ptr_reg;
    logic [bara_pkg::CMDQ_PTR_W-1:0]    wr_ptr_next;
    logic [bara_pkg::CMDQ_PTR_W-1:0]    rd_ptr_reg;
    logic [bara_pkg::CMDQ_PTR_W-1:0]    rd_ptr_next;
    logic [bara_pkg::CMDQ_CNT_W-1:0]    count_reg;
    logic [bara_pkg::CMDQ_CNT_W-1:0]    count_next;
    logic                               push_ok;
    logic                               take_ok;

    // Classify the incoming operation: word, offset, saturated range bounds.
    always_comb
    begin
        idx_ext   = bara_pkg::END_W'(bit_index);
        start_ext = bara_pkg::END_W'(range_start);
        if (range_end > bara_pkg::END_W'(bara_pkg::TOTAL_BITS))
        begin
            hi_sat = bara_pkg::END_W'(bara_pkg::TOTAL_BITS);
        end
        else
        begin
            hi_sat = range_end;
        end
        hi_m1 = hi_sat - bara_pkg::END_W'(1);

        cls.func        = func;
        cls.idx_ok      = idx_ext < bara_pkg::END_W'(bara_pkg::TOTAL_BITS);
        cls.word        = bara_pkg::WIDX_W'(bit_index >> bara_pkg::OFF_W);
        cls.offset      = bit_index[bara_pkg::OFF_W-1:0];
        cls.value       = bit_value;
        cls.range_empty = start_ext >= hi_sat;
        cls.first_word  = bara_pkg::WIDX_W'(range_start >> bara_pkg::OFF_W);
        cls.last_word   = bara_pkg::WIDX_W'(hi_m1 >> bara_pkg::OFF_W);
        cls.first_off   = range_start[bara_pkg::OFF_W-1:0];
        cls.last_end    = {1'b0, hi_m1[bara_pkg::OFF_W-1:0]} + (bara_pkg::OFF_W + 1)'(1);
    end

    // Queue control.
    assign full      = count_reg == bara_pkg::CMDQ_CNT_W'(bara_pkg::CMDQ_DEPTH);
    assign cmd_valid = count_reg != '0;
    assign cmd       = q_mem_reg[rd_ptr_reg];
    assign push_ok   = push && !full;
    assign take_ok   = cmd_take && cmd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            if (wr_ptr_reg == bara_pkg::CMDQ_PTR_W'(bara_pkg::CMDQ_DEPTH - 1))
            begin
                wr_ptr_next = '0;
            end
            else
            begin
                wr_ptr_next = wr_ptr_reg + bara_pkg::CMDQ_PTR_W'(1);
            end
        end
        if (take_ok)
        begin
            if (rd_ptr_reg == bara_pkg::CMDQ_PTR_W'(bara_pkg::CMDQ_DEPTH - 1))
            begin
                rd_ptr_next = '0;
            end
            else
            begin
                rd_ptr_next = rd_ptr_reg + bara_pkg::CMDQ_PTR_W'(1);
            end
        end
        if (push_ok && !take_ok)
        begin
            count_next = count_reg + bara_pkg::CMDQ_CNT_W'(1);
        end
        else if (take_ok && !push_ok)
        begin
            count_next = count_reg - bara_pkg::CMDQ_CNT_W'(1);
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage; the payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            q_mem_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bara_back.sv =====
// Back end: holds the word store, carries out clear, get, set and range scans,
// and keeps the result register. Depends on bara_pkg.
`default_nettype none

module bara_back
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    input  wire bara_pkg::cmd_t cmd,
    output logic                cmd_take,
    output logic                empty,
    input  wire logic           pop,
    output logic                result_bit
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_GET    = 3'd1;
    localparam logic [2:0] ST_SET    = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_RESULT = 3'd4;

    localparam int                   SCAN_W   = bara_pkg::WIDX_W + 1;
    localparam bara_pkg::word_t      ALL_ONES = '1;
    localparam logic [bara_pkg::OFF_W-1:0] TOP_OFF = bara_pkg::OFF_W'(bara_pkg::WORD_BITS - 1);

    // Word store with one valid bit per word; an invalid word reads as zero.
    bara_pkg::word_t                  mem [bara_pkg::WORD_COUNT];
    bara_pkg::word_t                  mem_rdata_reg;
    logic                             rd_valid_reg;
    logic [bara_pkg::WORD_COUNT-1:0]  valid_reg;
    logic [bara_pkg::WORD_COUNT-1:0]  valid_next;
    logic                             mem_re;
    logic [bara_pkg::WIDX_W-1:0]      mem_raddr;
    logic                             mem_we;
    bara_pkg::word_t                  mem_wdata;
    bara_pkg::word_t                  rdata_eff;

    logic [2:0]                       state_reg;
    logic [2:0]                       state_next;
    bara_pkg::cmd_t                   cur_reg;
    bara_pkg::cmd_t                   cur_next;
    logic [SCAN_W-1:0]                scan_addr_reg;
    logic [SCAN_W-1:0]                scan_addr_next;
    logic [bara_pkg::WIDX_W-1:0]      chk_word_reg;
    logic [bara_pkg::WIDX_W-1:0]      chk_word_next;
    logic                             chk_valid_reg;
    logic                             chk_valid_next;
    logic                             res_reg;
    logic                             res_next;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic                             out_bit_reg;
    logic                             out_bit_next;

    logic [bara_pkg::OFF_W:0]         lo_sh;
    logic [bara_pkg::OFF_W:0]         hi_sh;
    bara_pkg::word_t                  range_mask;
    bara_pkg::word_t                  bit_mask;
    logic                             issue;
    logic                             hit;
    logic                             at_last;
    logic                             load_out;
    logic                             pop_ok;

    assign rdata_eff = rd_valid_reg ? mem_rdata_reg : '0;

    // Mask of the range bits that fall inside the word under check.
    always_comb
    begin
        if (chk_word_reg == cur_reg.first_word)
        begin
            lo_sh = {1'b0, cur_reg.first_off};
        end
        else
        begin
            lo_sh = '0;
        end
        if (chk_word_reg == cur_reg.last_word)
        begin
            hi_sh = cur_reg.last_end;
        end
        else
        begin
            hi_sh = (bara_pkg::OFF_W + 1)'(bara_pkg::WORD_BITS);
        end
        range_mask = (ALL_ONES >> lo_sh) & ~(ALL_ONES >> hi_sh);
        bit_mask   = bara_pkg::word_t'(1) << (TOP_OFF - cur_reg.offset);
    end

    assign issue   = scan_addr_reg <= {1'b0, cur_reg.last_word};
    assign hit     = chk_valid_reg && ((rdata_eff & range_mask) != '0);
    assign at_last = chk_valid_reg && (chk_word_reg == cur_reg.last_word);
    assign pop_ok  = pop && out_valid_reg;
    assign load_out = (state_reg == ST_RESULT) && (!out_valid_reg || pop);

    // Sequencer for the four operations.
    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        scan_addr_next = scan_addr_reg;
        chk_word_next  = chk_word_reg;
        chk_valid_next = chk_valid_reg;
        res_next       = res_reg;
        valid_next     = valid_reg;
        cmd_take       = 1'b0;
        mem_re         = 1'b0;
        mem_raddr      = scan_addr_reg[bara_pkg::WIDX_W-1:0];
        mem_we         = 1'b0;
        mem_wdata      = rdata_eff;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take       = 1'b1;
                    cur_next       = cmd;
                    scan_addr_next = {1'b0, cmd.first_word};
                    chk_valid_next = 1'b0;
                    res_next       = 1'b0;
                    case (cmd.func)
                        bara_pkg::FUNC_CLEAR:
                        begin
                            valid_next = '0;
                        end
                        bara_pkg::FUNC_GET:
                        begin
                            if (cmd.idx_ok)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = cmd.word;
                                state_next = ST_GET;
                            end
                            else
                            begin
                                state_next = ST_RESULT;
                            end
                        end
                        bara_pkg::FUNC_SET:
                        begin
                            if (cmd.idx_ok)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = cmd.word;
                                state_next = ST_SET;
                            end
                        end
                        default:
                        begin
                            if (cmd.range_empty)
                            begin
                                state_next = ST_RESULT;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                    endcase
                end
            end
            ST_GET:
            begin
                res_next   = rdata_eff[TOP_OFF - cur_reg.offset];
                state_next = ST_RESULT;
            end
            ST_SET:
            begin
                mem_we = 1'b1;
                if (cur_reg.value)
                begin
                    mem_wdata = rdata_eff | bit_mask;
                end
                else
                begin
                    mem_wdata = rdata_eff & ~bit_mask;
                end
                valid_next[cur_reg.word] = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                // Reads are issued one word a cycle; each word is checked on its registered read data.
                if (hit || at_last)
                begin
                    res_next       = hit;
                    chk_valid_next = 1'b0;
                    state_next     = ST_RESULT;
                end
                else if (issue)
                begin
                    mem_re         = 1'b1;
                    scan_addr_next = scan_addr_reg + SCAN_W'(1);
                    chk_word_next  = scan_addr_reg[bara_pkg::WIDX_W-1:0];
                    chk_valid_next = 1'b1;
                end
                else
                begin
                    chk_valid_next = 1'b0;
                end
            end
            ST_RESULT:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result register towards the output port.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_bit_next   = out_bit_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_bit_next   = res_reg;
        end
        else if (pop_ok)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign empty      = !out_valid_reg;
    assign result_bit = out_bit_reg;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chk_valid_reg <= 1'b0;
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chk_valid_reg <= chk_valid_next;
            valid_reg     <= valid_next;
            if (mem_re)
            begin
                rd_valid_reg <= valid_reg[mem_raddr];
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        scan_addr_reg <= scan_addr_next;
        chk_word_reg  <= chk_word_next;
        res_reg       <= res_next;
        out_bit_reg   <= out_bit_next;
    end

    // Word store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[cur_reg.word] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    // The store is written only in the write-back step of a set.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_SET))
        else $error("store written outside a set");

    // A result never overwrites one that has not been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> ($stable(out_bit_reg) && out_valid_reg))
        else $error("waiting result was overwritten");

    // Commands leave the queue only when the sequencer is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> (state_reg == ST_IDLE))
        else $error("command taken while busy");

    // A pending word check exists only during a range scan.
    assert property (@(posedge clk) disable iff (!rst_n)
        chk_valid_reg |-> (state_reg == ST_SCAN))
        else $error("word check pending outside a scan");

    // A clear leaves every word reading as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_take && (cmd.func == bara_pkg::FUNC_CLEAR)) |=> (valid_reg == '0))
        else $error("clear left a word valid");

endmodule

`default_nettype wire
